[hdl/pll_pkg.sv]
package pll_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_EVENT    = 2'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_TIME_BACK = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_WRONG     = 3'd5;
    localparam logic [2:0] ST_UNDERFLOW = 3'd6;
    localparam logic [2:0] ST_FULL      = 3'd7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        task_key;
        logic [5:0]         node_index;
        logic               is_recovery;
        logic               activate;
        logic signed [63:0] time_ns;
    } pll_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         event_kind;
        logic [31:0]        event_task;
        logic [5:0]         event_node;
        logic signed [63:0] event_time;
        logic [8:0]         backup_active;
        logic [31:0]        backup_total;
        logic [8:0]         backup_peak;
        logic [8:0]         recovery_active;
        logic [31:0]        recovery_total;
        logic [8:0]         recovery_peak;
        logic               ledger_empty;
    } pll_rsp_t;

endpackage

[hdl/pll_chan_if.sv]
interface pll_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/placement_load_ledger.sv]
// A register or query result goes through ST_DONE into the response register, loaded once
// rsp.ready or an empty register allows. An ownership event scans its table one slot a cycle
// through the registered memory read; a hit ends the scan, a miss covers all OWNER_SLOTS.
// One transaction is in flight; the next is taken the cycle after its result is loaded, and
// a result may wait for rsp.ready while the next is taken.
// Reset (rst_n, asynchronous, active low) clears nodes and occupancies, then a clearing pass
// over all 2**(SW+1) entries invalidates every ownership slot while req.ready stays low.
module placement_load_ledger
    import pll_pkg::*;
#(
    parameter int NODE_COUNT  = 64,
    parameter int OWNER_SLOTS = 256
)
(
    input logic        clk,
    input logic        rst_n,
    pll_chan_if.sink   req,
    pll_chan_if.source rsp
);

    localparam int SW  = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int AW  = $clog2(OWNER_SLOTS + 1);
    localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    typedef struct packed {
        logic [AW-1:0] active;
        logic [31:0]   total;
        logic [AW-1:0] peak;
    } cnt_t;

    typedef cnt_t [1:0] cnt_pair_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [5:0]  owner;
    } own_ent_t;

    state_t state_reg, state_next;

    pll_req_t            item_reg;
    logic [NIW-1:0]      addr_reg;
    logic                inrange_reg;
    cnt_pair_t           ctr_mem [0:(2**NIW)-1];
    cnt_pair_t           ctr_rd_reg;
    own_ent_t            own_mem [0:(2**(SW+1))-1];
    own_ent_t            own_rd_reg;
    logic [SW:0]         clr_idx_reg;
    logic [AW-1:0]       bocc_reg, rocc_reg;
    logic [63:0]         last_time_reg;
    logic                has_event_reg;
    logic [NODE_COUNT-1:0] nreg_reg;
    logic [SW:0]         scan_idx_reg;
    logic                cmp_pend_reg;
    logic [SW-1:0]       cmp_idx_reg;
    logic                found_reg;
    logic [SW-1:0]       found_idx_reg;
    logic [5:0]          owner_reg;
    logic                free_found_reg;
    logic [SW-1:0]       free_idx_reg;
    logic                rsp_valid_reg;
    pll_rsp_t            rsp_data_reg;

    logic                accept, load;
    logic [NIW+5:0]      node_ext;
    logic                issue, match, rec;
    logic [SW-1:0]       scan_slot;

    pll_rsp_t            res;
    cnt_pair_t           nc, cnt_o;
    logic                known, time_bad, est_ok, rel_ok, reg_new;
    logic [AW-1:0]       occ, bocc_next, rocc_next;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign load      = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    assign node_ext  = {{NIW{1'b0}}, req.payload.node_index};
    assign rec       = item_reg.is_recovery;
    assign issue     = scan_idx_reg < (SW+1)'(OWNER_SLOTS);
    assign scan_slot = scan_idx_reg[SW-1:0];
    assign match     = cmp_pend_reg && own_rd_reg.valid && (own_rd_reg.key == item_reg.task_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = (req.payload.opcode == OP_EVENT) ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (match || (!issue && !cmp_pend_reg))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result and state update, used when the result is loaded in ST_DONE (after the scan, for an event).
    always_comb
    begin
        cnt_pair_t cur;
        cnt_t      kc;
        cur      = ctr_rd_reg;
        nc       = cur;
        kc       = cur[rec];
        known    = inrange_reg && nreg_reg[addr_reg];
        occ      = rec ? rocc_reg : bocc_reg;
        time_bad = item_reg.time_ns[63] ||
                   (has_event_reg && (unsigned'(item_reg.time_ns) < last_time_reg));
        est_ok   = 1'b0;
        rel_ok   = 1'b0;
        reg_new  = 1'b0;
        res      = '0;
        res.event_node = item_reg.node_index;

        if (item_reg.opcode == OP_REGISTER)
        begin
            if (!inrange_reg)
                res.status = ST_UNKNOWN;
            else
            begin
                res.status = ST_OK;
                reg_new    = !known;
            end
        end
        else if (item_reg.opcode != OP_EVENT)
            res.status = known ? ST_OK : ST_UNKNOWN;
        else
        begin
            res.event_kind = {rec, !item_reg.activate};
            res.event_task = item_reg.task_key;
            res.event_time = item_reg.time_ns;
            priority if (!item_reg.activate && !found_reg)
                res.status = ST_IGNORED;
            else if (time_bad)
                res.status = ST_TIME_BACK;
            else if (!known)
                res.status = ST_UNKNOWN;
            else if (item_reg.activate && found_reg)
                res.status = ST_DUPLICATE;
            else if (item_reg.activate && (!free_found_reg || occ >= AW'(OWNER_SLOTS)))
                res.status = ST_FULL;
            else if (item_reg.activate)
            begin
                res.status = ST_OK;
                est_ok     = 1'b1;
                kc.active  = kc.active + AW'(1);
                if (kc.total != 32'hFFFF_FFFF)
                    kc.total = kc.total + 32'd1;
                if (kc.peak < kc.active)
                    kc.peak = kc.active;
            end
            else if (owner_reg != item_reg.node_index)
                res.status = ST_WRONG;
            else if (kc.active == '0)
                res.status = ST_UNDERFLOW;
            else
            begin
                res.status = ST_OK;
                rel_ok     = 1'b1;
                kc.active  = kc.active - AW'(1);
            end
            nc[rec] = kc;
        end

        cnt_o = known ? nc : '0;
        res.backup_active   = 9'(cnt_o[0].active);
        res.backup_total    = cnt_o[0].total;
        res.backup_peak     = 9'(cnt_o[0].peak);
        res.recovery_active = 9'(cnt_o[1].active);
        res.recovery_total  = cnt_o[1].total;
        res.recovery_peak   = 9'(cnt_o[1].peak);

        bocc_next = bocc_reg;
        rocc_next = rocc_reg;
        if (est_ok)
        begin
            if (rec)
                rocc_next = rocc_reg + AW'(1);
            else
                bocc_next = bocc_reg + AW'(1);
        end
        if (rel_ok)
        begin
            if (rec)
                rocc_next = rocc_reg - AW'(1);
            else
                bocc_next = bocc_reg - AW'(1);
        end
        res.ledger_empty = (bocc_next == '0) && (rocc_next == '0);
    end

    // Counter memory: read when a transaction is taken, written back on completion.
    always_ff @(posedge clk)
    begin
        if (accept)
            ctr_rd_reg <= ctr_mem[node_ext[NIW-1:0]];
        if (load && reg_new)
            ctr_mem[addr_reg] <= '0;
        else if (load && (est_ok || rel_ok))
            ctr_mem[addr_reg] <= nc;
    end

    // Ownership memory: both tables share it, the table bit being the top address bit.
    // Each entry carries its own valid bit, cleared by the pass after reset and on release.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && issue)
            own_rd_reg <= own_mem[{rec, scan_slot}];
        if (state_reg == ST_CLEAR)
            own_mem[clr_idx_reg] <= '0;
        else if (load && est_ok)
            own_mem[{rec, free_idx_reg}] <= '{valid: 1'b1, key: item_reg.task_key,
                                              owner: item_reg.node_index};
        else if (load && rel_ok)
            own_mem[{rec, found_idx_reg}] <= '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= req.payload;
            addr_reg    <= node_ext[NIW-1:0];
            inrange_reg <= node_ext < (NIW+6)'(NODE_COUNT);
        end
        if (state_reg == ST_SCAN && match)
        begin
            found_idx_reg <= cmp_idx_reg;
            owner_reg     <= own_rd_reg.owner;
        end
        if (state_reg == ST_SCAN && cmp_pend_reg && !own_rd_reg.valid && !free_found_reg)
            free_idx_reg <= cmp_idx_reg;
        if (state_reg == ST_SCAN && issue)
            cmp_idx_reg <= scan_slot;
        if (load)
            rsp_data_reg <= res;
        if (load && est_ok && !time_bad)
            last_time_reg <= item_reg.time_ns;
        else if (load && rel_ok)
            last_time_reg <= item_reg.time_ns;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            bocc_reg       <= '0;
            rocc_reg       <= '0;
            has_event_reg  <= 1'b0;
            nreg_reg       <= '0;
            scan_idx_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
                clr_idx_reg <= clr_idx_reg + (SW+1)'(1);
            if (accept)
            begin
                scan_idx_reg   <= '0;
                cmp_pend_reg   <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (match)
                    found_reg <= 1'b1;
                if (cmp_pend_reg && !own_rd_reg.valid)
                    free_found_reg <= 1'b1;
                if (issue)
                begin
                    cmp_pend_reg <= 1'b1;
                    scan_idx_reg <= scan_idx_reg + (SW+1)'(1);
                end
                else
                    cmp_pend_reg <= 1'b0;
            end

            rsp_valid_reg <= load || (rsp_valid_reg && !rsp.ready);
            if (load)
            begin
                bocc_reg      <= bocc_next;
                rocc_reg      <= rocc_next;
                if (reg_new)
                    nreg_reg[addr_reg] <= 1'b1;
                if (est_ok || rel_ok)
                    has_event_reg <= 1'b1;
            end
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (bocc_reg <= AW'(OWNER_SLOTS)) && (rocc_reg <= AW'(OWNER_SLOTS)))
        else $error("ownership occupancy above table size");

    a_empty_before_event: assert property (@(posedge clk) disable iff (!rst_n)
        !has_event_reg |-> (bocc_reg == '0) && (rocc_reg == '0))
        else $error("live task without any recorded event");

    a_backup_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (load && est_ok && !rec) |=> (bocc_reg == $past(bocc_reg) + AW'(1)))
        else $error("backup occupancy did not follow an establish");

    a_scan_done_only: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (est_ok || rel_ok)) |-> (item_reg.opcode == OP_EVENT) && known)
        else $error("table change outside a valid event");

endmodule
